// ===== hdl/pfs_pkg.sv =====
// Shared types, codes and helpers for the protobuf field serializer.
package pfs_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int VALUE_W         = 64;
    localparam int TAG_W           = 29;
    localparam int TAG_WORD_W      = 32;
    localparam int GROUP_W         = 7;
    localparam int TOTAL_W         = 32;
    localparam int IN_TDATA_W      = 104;
    localparam int OUT_TDATA_W     = 40;
    localparam int PADDR_W         = 3;

    localparam logic [1:0] CMD_VARINT = 2'd0;
    localparam logic [1:0] CMD_FIELD  = 2'd1;
    localparam logic [1:0] CMD_STRING = 2'd2;
    localparam logic [1:0] CMD_RAW    = 2'd3;

    localparam logic [2:0] WIRE_VARINT = 3'd0;
    localparam logic [2:0] WIRE_LEN    = 3'd2;

    // word index of the count_only register (paddr[2])
    localparam logic REG_COUNT_ONLY = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_TAG  = 4'b0010,
        ST_VAL  = 4'b0100,
        ST_RAW  = 4'b1000
    } pfs_state_t;

    typedef struct packed {
        logic load_tag;      // shifter <= tag word, hold <= value
        logic load_val_in;   // shifter <= incoming value
        logic load_val_hold; // shifter <= held value
        logic shift;         // shifter >>= 7
    } pfs_ctl_t;

    typedef struct packed {
        logic       valid;
        logic       last;
        logic [7:0] data;
    } pfs_emit_t;

    function automatic logic [TAG_WORD_W-1:0] tag_word(input logic [TAG_W-1:0] tag,
                                                       input logic [1:0] cmd);
        logic [2:0] wire_type;
        wire_type = (cmd == CMD_STRING) ? WIRE_LEN : WIRE_VARINT;
        return {tag, wire_type};
    endfunction

endpackage

// ===== hdl/protobuf_field_serializer.sv =====
// Flow: an accepted item loads the shifter or raw register; its bytes are then
// registered in the output slot. Throughput: one byte per cycle unless the output
// stalls, a rate set by the one shared 7-bit group shifter. Input waits until all
// N bytes of an item are emitted: raw byte 1, bare varint 1..10, field or header 2..15.
// Reset (rst_n, async, low) clears the byte counter, count_only and the sequencer.
module protobuf_field_serializer
    import pfs_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tag_number[28:0], value[92:29], data_byte[100:93], zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // cmd[1:0]
    input  logic [1:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // out_byte[7:0], byte_total[39:8]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // sent[0]
    output logic                   m_axis_tuser,
    output logic                   m_axis_tlast,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [TAG_W-1:0]       tag_number;
    logic [VALUE_W-1:0]     value;
    logic [7:0]             data_byte;
    logic [1:0]             cmd;
    pfs_ctl_t               ctl;
    pfs_emit_t              emit;
    logic [7:0]             grp_byte;
    logic                   more;
    logic                   adv;

    logic                   count_only_reg;
    logic                   count_only_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   o_valid_reg;
    logic                   o_valid_next;
    logic                   o_last_reg;
    logic                   o_last_next;
    logic                   o_sent_reg;
    logic                   o_sent_next;
    logic [7:0]             o_byte_reg;
    logic [7:0]             o_byte_next;
    logic [TOTAL_W-1:0]     o_total_reg;
    logic [TOTAL_W-1:0]     o_total_next;

    assign cmd        = s_axis_tuser;
    assign tag_number = s_axis_tdata[TAG_W-1:0];
    assign value      = s_axis_tdata[TAG_W+VALUE_W-1:TAG_W];
    assign data_byte  = s_axis_tdata[TAG_W+VALUE_W+7:TAG_W+VALUE_W];

    // the output slot takes a new byte when empty or being drained
    assign adv = !o_valid_reg || m_axis_tready;

    pfs_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .cmd       (cmd),
        .data_byte (data_byte),
        .adv       (adv),
        .grp_byte  (grp_byte),
        .more      (more),
        .ctl       (ctl),
        .emit      (emit)
    );

    pfs_varint_unit u_varint (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .tag_in   (tag_word(tag_number, cmd)),
        .value_in (value),
        .grp_byte (grp_byte),
        .more     (more)
    );

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_COUNT_ONLY) ? {31'd0, count_only_reg} : 32'd0;

    always_comb
    begin
        count_only_next = count_only_reg;
        if (psel && penable && pwrite && pready && paddr[2] == REG_COUNT_ONLY)
        begin
            count_only_next = pwdata[0];
        end
    end

    // output register and running byte count
    always_comb
    begin
        count_next   = count_reg;
        o_valid_next = o_valid_reg;
        o_last_next  = o_last_reg;
        o_sent_next  = o_sent_reg;
        o_byte_next  = o_byte_reg;
        o_total_next = o_total_reg;
        if (adv)
        begin
            o_valid_next = emit.valid;
            if (emit.valid)
            begin
                count_next   = count_reg + COUNT_WIDTH'(1);
                o_last_next  = emit.last;
                o_sent_next  = !count_only_reg;
                o_byte_next  = emit.data;
                o_total_next = TOTAL_W'(count_next);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_only_reg <= 1'b0;
            count_reg      <= '0;
            o_valid_reg    <= 1'b0;
        end
        else
        begin
            count_only_reg <= count_only_next;
            count_reg      <= count_next;
            o_valid_reg    <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        o_last_reg  <= o_last_next;
        o_sent_reg  <= o_sent_next;
        o_byte_reg  <= o_byte_next;
        o_total_reg <= o_total_next;
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tlast  = o_last_reg;
    assign m_axis_tuser  = o_sent_reg;
    assign m_axis_tdata  = {o_total_reg, o_byte_reg};

`ifndef SYNTHESIS
    a_busy_mid_item: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && !o_last_reg |-> !s_axis_tready)
        else $error("input taken while an item is still being emitted");
`endif

endmodule

// ===== hdl/pfs_varint_unit.sv =====
// Shared 7-bit group shifter that walks a tag or value out as varint bytes.
module pfs_varint_unit
    import pfs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pfs_ctl_t              ctl,
    input  logic [TAG_WORD_W-1:0] tag_in,
    input  logic [VALUE_W-1:0]    value_in,
    output logic [7:0]            grp_byte,
    output logic                  more
);

    logic [VALUE_W-1:0] shift_reg;
    logic [VALUE_W-1:0] shift_next;
    logic [VALUE_W-1:0] hold_reg;
    logic [VALUE_W-1:0] hold_next;

    assign more     = |shift_reg[VALUE_W-1:GROUP_W];
    assign grp_byte = {more, shift_reg[GROUP_W-1:0]};

    always_comb
    begin
        shift_next = shift_reg;
        hold_next  = hold_reg;
        if (ctl.load_tag)
        begin
            shift_next = VALUE_W'(tag_in);
            hold_next  = value_in;
        end
        else if (ctl.load_val_in)
        begin
            shift_next = value_in;
        end
        else if (ctl.load_val_hold)
        begin
            shift_next = hold_reg;
        end
        else if (ctl.shift)
        begin
            shift_next = shift_reg >> GROUP_W;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
            hold_reg  <= '0;
        end
        else
        begin
            shift_reg <= shift_next;
            hold_reg  <= hold_next;
        end
    end

endmodule

// ===== hdl/pfs_seq.sv =====
// Command sequencer: steps the shared shifter and picks each emitted byte.
module pfs_seq
    import pfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] cmd,
    input  logic [7:0] data_byte,
    input  logic       adv,
    input  logic [7:0] grp_byte,
    input  logic       more,
    output pfs_ctl_t   ctl,
    output pfs_emit_t  emit
);

    pfs_state_t state_reg;
    pfs_state_t state_next;
    logic [7:0] raw_reg;
    logic [7:0] raw_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        raw_next   = raw_reg;
        ctl        = '0;
        emit       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (cmd) inside
                        CMD_VARINT:
                        begin
                            ctl.load_val_in = 1'b1;
                            state_next      = ST_VAL;
                        end
                        CMD_FIELD, CMD_STRING:
                        begin
                            ctl.load_tag = 1'b1;
                            state_next   = ST_TAG;
                        end
                        default:
                        begin
                            raw_next   = data_byte;
                            state_next = ST_RAW;
                        end
                    endcase
                end
            end
            ST_TAG:
            begin
                if (adv)
                begin
                    emit.valid = 1'b1;
                    emit.data  = grp_byte;
                    if (more)
                    begin
                        ctl.shift = 1'b1;
                    end
                    else
                    begin
                        ctl.load_val_hold = 1'b1;
                        state_next        = ST_VAL;
                    end
                end
            end
            ST_VAL:
            begin
                if (adv)
                begin
                    emit.valid = 1'b1;
                    emit.data  = grp_byte;
                    if (more)
                    begin
                        ctl.shift = 1'b1;
                    end
                    else
                    begin
                        emit.last  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RAW:
            begin
                if (adv)
                begin
                    emit.valid = 1'b1;
                    emit.last  = 1'b1;
                    emit.data  = raw_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            raw_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            raw_reg   <= raw_next;
        end
    end

`ifndef SYNTHESIS
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid && emit.last |=> state_reg == ST_IDLE)
        else $error("sequencer busy after last byte");

    a_tag_to_val: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TAG && adv && !more |=> state_reg == ST_VAL)
        else $error("tag end did not start value");

    a_cont_bit: assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid && (state_reg == ST_TAG || state_reg == ST_VAL)
            |-> emit.data[7] == !(emit.last || state_reg == ST_TAG && !more))
        else $error("continuation bit mismatch");
`endif

endmodule

// ===== sim/pfs_checker.sv =====
// Checker for the protobuf field serializer: predicts wire bytes and compares them.
module pfs_checker
    import pfs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [1:0]             s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   m_axis_tuser,
    input  logic                   m_axis_tlast,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [31:0]            pwdata,
    input  logic [31:0]            prdata,
    input  logic                   pready,
    output int                     fail_count,
    output int                     bytes_pending,
    output int                     bytes_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               sent;
        logic [TOTAL_W-1:0] byte_total;
        logic               last;
    } wire_byte_t;

    wire_byte_t               wire_bytes_q[$];
    logic                     count_only_mode;
    logic [COUNT_WIDTH_DEF-1:0] running_total;

    task automatic emit_byte(input logic [7:0] b, input logic is_last);
        wire_byte_t e;
        running_total = running_total + COUNT_WIDTH_DEF'(1);
        e.out_byte    = b;
        e.sent        = !count_only_mode;
        e.byte_total  = running_total[TOTAL_W-1:0];
        e.last        = is_last;
        wire_bytes_q.push_back(e);
    endtask

    // Seven bits per byte, low group first; continuation bit on all but the final group.
    task automatic emit_varint(input logic [VALUE_W-1:0] v, input logic ends_item);
        logic [VALUE_W-1:0] rest;
        rest = v;
        while (rest > 64'h7F)
        begin
            emit_byte({1'b1, rest[GROUP_W-1:0]}, 1'b0);
            rest = rest >> GROUP_W;
        end
        emit_byte({1'b0, rest[GROUP_W-1:0]}, ends_item);
    endtask

    task automatic predict_wire_bytes(input logic [1:0] cmd, input logic [TAG_W-1:0] tag,
                                      input logic [VALUE_W-1:0] value,
                                      input logic [7:0] data_byte);
        logic [2:0] wire_kind;
        wire_kind = (cmd == CMD_STRING) ? WIRE_LEN : WIRE_VARINT;
        case (cmd)
            CMD_VARINT:
                emit_varint(value, 1'b1);
            CMD_FIELD, CMD_STRING:
            begin
                emit_varint({32'd0, tag, wire_kind}, 1'b0);
                emit_varint(value, 1'b1);
            end
            default:
                emit_byte(data_byte, 1'b1);
        endcase
    endtask

    task automatic check_wire_byte();
        wire_byte_t exp_b;
        if (wire_bytes_q.size() == 0)
        begin
            $error("unexpected output byte %h", m_axis_tdata[7:0]);
            fail_count++;
        end
        else
        begin
            exp_b = wire_bytes_q.pop_front();
            bytes_checked++;
            if (m_axis_tdata[7:0] !== exp_b.out_byte)
            begin
                $error("out_byte: expected %h, actual %h", exp_b.out_byte, m_axis_tdata[7:0]);
                fail_count++;
            end
            if (m_axis_tuser !== exp_b.sent)
            begin
                $error("sent: expected %b, actual %b", exp_b.sent, m_axis_tuser);
                fail_count++;
            end
            if (m_axis_tdata[39:8] !== exp_b.byte_total)
            begin
                $error("byte_total: expected %0d, actual %0d", exp_b.byte_total,
                       m_axis_tdata[39:8]);
                fail_count++;
            end
            if (m_axis_tlast !== exp_b.last)
            begin
                $error("last: expected %b, actual %b", exp_b.last, m_axis_tlast);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wire_bytes_q.delete();
            count_only_mode = 1'b0;
            running_total   = '0;
            fail_count      = 0;
            bytes_pending   = 0;
            bytes_checked   = 0;
        end
        else
        begin
            if (psel && penable && pready && paddr[PADDR_W-1] == REG_COUNT_ONLY)
            begin
                if (pwrite)
                    count_only_mode = pwdata[0];
                else if (prdata !== {31'd0, count_only_mode})
                begin
                    $error("count_only readback: expected %h, actual %h",
                           {31'd0, count_only_mode}, prdata);
                    fail_count++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_wire_bytes(s_axis_tuser, s_axis_tdata[28:0], s_axis_tdata[92:29],
                                   s_axis_tdata[100:93]);
            if (m_axis_tvalid && m_axis_tready)
                check_wire_byte();
            bytes_pending = wire_bytes_q.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the protobuf field serializer: clock, reset, stimulus and verdict.
module tb_top;
    import pfs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [PADDR_W-1:0] ADDR_COUNT_ONLY = {REG_COUNT_ONLY, 2'b00};
    localparam int                 HOLD_CYCLES     = 300;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [1:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    int fail_count;
    int bytes_pending;
    int bytes_checked;
    int commands_sent;
    int tx_idle_pct;
    int rx_idle_pct;
    logic hold_req;

    protobuf_field_serializer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    pfs_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .bytes_pending (bytes_pending),
        .bytes_checked (bytes_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        logic hold_done;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [31:0] wdata);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = wr;
        penable = 1'b0;
        paddr   = addr;
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_count_only(input logic mode);
        apb_access(1'b1, ADDR_COUNT_ONLY, {31'd0, mode});
        apb_access(1'b0, ADDR_COUNT_ONLY, 32'd0);
    endtask

    // Wait until every predicted byte has come out, then let the pipeline settle.
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (bytes_pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic send_command(input logic [1:0] cmd, input logic [TAG_W-1:0] tag,
                                input logic [VALUE_W-1:0] value, input logic [7:0] data_byte);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = {3'b000, data_byte, value, tag};
        do
            @(posedge clk);
        while (!s_axis_tready);
        commands_sent++;
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        int                 nbits;
        v     = {$urandom, $urandom};
        nbits = $urandom_range(VALUE_W, 1);
        if ($urandom_range(15) == 0)
            return '0;
        return v >> (VALUE_W - nbits);
    endfunction

    function automatic logic [TAG_W-1:0] random_tag();
        logic [TAG_W-1:0] t;
        int               nbits;
        t     = TAG_W'($urandom);
        nbits = $urandom_range(TAG_W, 1);
        return t >> (TAG_W - nbits);
    endfunction

    // Mostly well-formed fields, length-prefixed strings and bare varints, with some noise items.
    task automatic send_traffic(input int count);
        int sent_here;
        int pick;
        int str_len;
        sent_here = 0;
        while (sent_here < count)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                send_command(CMD_FIELD, random_tag(), random_value(), 8'($urandom));
                sent_here++;
            end
            else if (pick < 70)
            begin
                str_len = $urandom_range(6);
                send_command(CMD_STRING, random_tag(), VALUE_W'(str_len), 8'($urandom));
                repeat (str_len)
                    send_command(CMD_RAW, TAG_W'($urandom), {$urandom, $urandom},
                                 8'($urandom));
                sent_here += 1 + str_len;
            end
            else if (pick < 85)
            begin
                send_command(CMD_VARINT, TAG_W'($urandom), random_value(), 8'($urandom));
                sent_here++;
            end
            else
            begin
                send_command(2'($urandom_range(3)), TAG_W'($urandom), {$urandom, $urandom},
                             8'($urandom));
                sent_here++;
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_VARINT;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        hold_req      = 1'b0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        commands_sent = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_count_only(1'b0);

        // Varint length boundaries, tag size boundaries, raw byte extremes.
        send_command(CMD_VARINT, '1, 64'd0, 8'hFF);
        send_command(CMD_VARINT, '0, 64'h7F, 8'h00);
        send_command(CMD_VARINT, '1, 64'h80, 8'hFF);
        send_command(CMD_VARINT, '0, 64'h3FFF, 8'h00);
        send_command(CMD_VARINT, '1, 64'h4000, 8'hFF);
        send_command(CMD_VARINT, '0, 64'h8000_0000_0000_0000, 8'h00);
        send_command(CMD_VARINT, '0, '1, 8'h00);
        send_command(CMD_FIELD, '0, 64'd0, 8'hFF);
        send_command(CMD_FIELD, 29'd15, 64'd1, 8'h00);
        send_command(CMD_FIELD, 29'd16, 64'd150, 8'h00);
        send_command(CMD_FIELD, '1, '1, 8'hFF);
        send_command(CMD_STRING, 29'd1, 64'd0, 8'h00);
        send_command(CMD_STRING, '1, 64'd300, 8'hFF);
        send_command(CMD_STRING, 29'd2, '1, 8'h00);
        send_command(CMD_RAW, '1, '1, 8'h00);
        send_command(CMD_RAW, '0, '0, 8'hFF);
        send_command(CMD_RAW, '1, '1, 8'h80);
        send_command(CMD_RAW, '0, '0, 8'h7F);
        wait_drained();

        set_count_only(1'b1);
        tx_idle_pct = 10;
        rx_idle_pct = 85;
        send_traffic(150);
        wait_drained();

        set_count_only(1'b0);
        tx_idle_pct = 85;
        rx_idle_pct = 10;
        send_traffic(150);
        wait_drained();

        // Back-to-back traffic with one long output hold-off to fill the block.
        set_count_only(1'b1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = 1'b1;
        send_traffic(160);
        wait_drained();
        repeat (10) @(negedge clk);

        $display("Covered %0d commands and %0d serialized bytes in send and count-only modes,",
                 commands_sent, bytes_checked);
        $display("with stalls on both channels and a long output hold-off.");
        if (fail_count == 0 && bytes_pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/pfs_pkg.sv
hdl/pfs_varint_unit.sv
hdl/pfs_seq.sv
hdl/protobuf_field_serializer.sv
sim/pfs_checker.sv
sim/tb_top.sv
